>>> sv/sgwdp_pkg.sv
// Shared types, widths and constants of the stereo gain, width, drive and pan unit.
package sgwdp_pkg;

    // Sample width of the stream fields.
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Configuration register file.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int GAIN_W     = 24;
    localparam int COEF_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_AMOUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_RIGHT    = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UNITY    = 24'd1048576;
    localparam logic [COEF_W-1:0] WIDTH_UNITY   = 16'd16384;
    localparam logic [COEF_W-1:0] PAN_UNITY     = 16'd32768;
    localparam logic [11:0]       SMOOTH_COEF   = 12'd2097;
    localparam logic [11:0]       PI_Q10        = 12'd3217;
    localparam logic [COEF_W-1:0] DRIVE_ON      = 16'd512;

    // Internal channel width: mid plus a side scaled by up to four stays well inside this.
    localparam int CH_W    = SAMPLE_BITS + 8;
    localparam int MAG_W   = CH_W - 1;
    // Soft clip operands.
    localparam int CLIP_SH = FRAC_BITS - 10;
    localparam int A_W     = COEF_W + 1;
    localparam int AMAG_W  = A_W + MAG_W;
    localparam int KMAG_W  = COEF_W + MAG_W;
    localparam int NUM_W   = AMAG_W + CLIP_SH + 1;
    localparam int DEN_W   = KMAG_W - 10 + 1;
    // With the clip active the quotient stays below about 7.3 in sample units.
    localparam int QUO_W   = SAMPLE_BITS + 4;

    typedef struct packed {
        logic [GAIN_W-1:0] target_gain;
        logic [COEF_W-1:0] stereo_width;
        logic [COEF_W-1:0] drive_amount;
        logic [COEF_W-1:0] pan_left_gain;
        logic [COEF_W-1:0] pan_right_gain;
    } cfg_t;

    // Commands from the controller to the datapath and the divider.
    typedef struct packed {
        logic load_in;
        logic gain_mul;
        logic gain_upd;
        logic smp_mul;
        logic ms_mul;
        logic ms_add;
        logic clip_mul;
        logic clip_set;
        logic clip_store;
        logic pan_mul;
        logic pan_fin;
        logic ch;
    } cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic clip_en;
        logic div_done;
        logic out_busy;
    } stat_t;

endpackage

>>> sv/stereo_gain_width_drive_pan_unit.sv
// Top level of the stereo gain, width, drive and pan unit with its register file.
//
// Each stereo word passes through a smoothed gain, mid/side width scaling, an optional
// rational soft clip and constant-power pan gains, and leaves saturated to the sample
// width. One word is in work at a time: it goes through the gain and mid/side states,
// then, while drive_amount is above 512, through the soft clip, where both channels go
// in turn through one divider that produces one of its 28 quotient bits per cycle, and
// through the pan states; its result enters the output register once that is free. The
// next word can be accepted in the cycle after that, and the output register lets it be
// accepted while a result still waits on the master side. The user must write registers
// through cfg_we, cfg_index and cfg_data only while the unit is idle; the block does not
// enforce it. Indices beyond the last register are ignored.
module stereo_gain_width_drive_pan_unit
    import sgwdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,   // left_in, right_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,   // left_out, right_out
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                     cfg_reg;
    cmd_t                     cmd;
    stat_t                    stat;
    logic                     clip_en;
    logic                     out_busy;
    logic                     div_done;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic [QUO_W-1:0]         div_quo;
    logic [2*SAMPLE_BITS-1:0] out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_gain    <= GAIN_UNITY;
            cfg_reg.stereo_width   <= WIDTH_UNITY;
            cfg_reg.drive_amount   <= '0;
            cfg_reg.pan_left_gain  <= PAN_UNITY;
            cfg_reg.pan_right_gain <= PAN_UNITY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_GAIN:  cfg_reg.target_gain    <= cfg_data[GAIN_W-1:0];
                REG_STEREO_WIDTH: cfg_reg.stereo_width   <= cfg_data[COEF_W-1:0];
                REG_DRIVE_AMOUNT: cfg_reg.drive_amount   <= cfg_data[COEF_W-1:0];
                REG_PAN_LEFT:     cfg_reg.pan_left_gain  <= cfg_data[COEF_W-1:0];
                REG_PAN_RIGHT:    cfg_reg.pan_right_gain <= cfg_data[COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign stat.clip_en  = clip_en;
    assign stat.div_done = div_done;
    assign stat.out_busy = out_busy;

    assign m_axis_tdata = TDATA_W'(out_data);

    sgwdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgwdp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .in_data   (s_axis_tdata[2*SAMPLE_BITS-1:0]),
        .out_data  (out_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .clip_en   (clip_en),
        .out_busy  (out_busy),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_quo   (div_quo)
    );

    sgwdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.clip_set),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

endmodule

>>> sv/sgwdp_div.sv
// Restoring divider producing one quotient bit per cycle for the soft clip.
module sgwdp_div
    import sgwdp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int DSH_W = DEN_W + QUO_W - 1;
    localparam int CMP_W = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] dsh_ext;
    logic [CMP_W-1:0] diff;
    logic             ge;

    assign rem_ext = CMP_W'(rem_reg);
    assign dsh_ext = CMP_W'(dsh_reg);
    assign diff    = rem_ext - dsh_ext;
    assign ge      = (rem_ext >= dsh_ext);

    assign done = busy_reg && (cnt_reg == CNT_LAST);
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The divisor starts at its top quotient weight and walks down one bit a cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= DSH_W'(den) << (QUO_W - 1);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= diff[NUM_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

endmodule

>>> sv/sgwdp_ctrl.sv
// Controller state machine sequencing one stereo word through the datapath.
module sgwdp_ctrl
    import sgwdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_GAIN_MUL   = 4'd1;
    localparam logic [3:0] ST_GAIN_UPD   = 4'd2;
    localparam logic [3:0] ST_SMP_MUL    = 4'd3;
    localparam logic [3:0] ST_MS_MUL     = 4'd4;
    localparam logic [3:0] ST_MS_ADD     = 4'd5;
    localparam logic [3:0] ST_CLIP_MUL   = 4'd6;
    localparam logic [3:0] ST_CLIP_SET   = 4'd7;
    localparam logic [3:0] ST_CLIP_DIV   = 4'd8;
    localparam logic [3:0] ST_CLIP_STORE = 4'd9;
    localparam logic [3:0] ST_PAN_MUL    = 4'd10;
    localparam logic [3:0] ST_PAN_FIN    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ch_reg;
    logic       ch_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.ch     = ch_reg;
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_GAIN_MUL;
                end
            end
            ST_GAIN_MUL:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = ST_GAIN_UPD;
            end
            ST_GAIN_UPD:
            begin
                cmd.gain_upd = 1'b1;
                state_next   = ST_SMP_MUL;
            end
            ST_SMP_MUL:
            begin
                cmd.smp_mul = 1'b1;
                state_next  = ST_MS_MUL;
            end
            ST_MS_MUL:
            begin
                cmd.ms_mul = 1'b1;
                state_next = ST_MS_ADD;
            end
            ST_MS_ADD:
            begin
                cmd.ms_add = 1'b1;
                ch_next    = 1'b0;
                state_next = stat.clip_en ? ST_CLIP_MUL : ST_PAN_MUL;
            end
            ST_CLIP_MUL:
            begin
                cmd.clip_mul = 1'b1;
                state_next   = ST_CLIP_SET;
            end
            ST_CLIP_SET:
            begin
                cmd.clip_set = 1'b1;
                state_next   = ST_CLIP_DIV;
            end
            ST_CLIP_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_CLIP_STORE;
                end
            end
            ST_CLIP_STORE:
            begin
                cmd.clip_store = 1'b1;
                if (ch_reg)
                begin
                    state_next = ST_PAN_MUL;
                end
                else
                begin
                    ch_next    = 1'b1;
                    state_next = ST_CLIP_MUL;
                end
            end
            ST_PAN_MUL:
            begin
                cmd.pan_mul = 1'b1;
                state_next  = ST_PAN_FIN;
            end
            ST_PAN_FIN:
            begin
                // The result goes straight into the output register once it is free.
                if (!stat.out_busy)
                begin
                    cmd.pan_fin = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/sgwdp_dp.sv
// Datapath: gain smoothing, mid/side width, soft clip operands, pan and saturation.
module sgwdp_dp
    import sgwdp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  cfg_t                       cfg,
    input  logic [2*SAMPLE_BITS-1:0]   in_data,
    output logic [2*SAMPLE_BITS-1:0]   out_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       clip_en,
    output logic                       out_busy,
    output logic [NUM_W-1:0]           div_num,
    output logic [DEN_W-1:0]           div_den,
    input  logic [QUO_W-1:0]           div_quo
);

    localparam int GAIN_FRAC = 20;
    localparam int DELTA_W   = GAIN_W + 1;
    localparam int GPROD_W   = DELTA_W + 13;
    localparam int GSTEP_W   = GPROD_W - GAIN_FRAC;
    localparam int SMUL_W    = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W     = CH_W + 1;
    localparam int SPROD_W   = SUM_W + COEF_W + 1;
    localparam int PPROD_W   = CH_W + COEF_W + 1;
    localparam int PY_W      = PPROD_W - 15;

    localparam logic signed [GPROD_W-1:0] GAIN_RND  = GPROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [SMUL_W-1:0]  SMP_RND   = SMUL_W'(1) << (GAIN_FRAC - 1);
    localparam logic signed [SPROD_W-1:0] SIDE_RND  = SPROD_W'(1) << 14;
    localparam logic signed [PPROD_W-1:0] PAN_RND   = PPROD_W'(1) << 14;
    localparam logic [SAMPLE_BITS-1:0]    SAT_HI    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0]    SAT_LO    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Round, shift and saturate a pan product to the sample width.
    function automatic logic [SAMPLE_BITS-1:0] pan_sat(input logic signed [PPROD_W-1:0] p);
        logic signed [PPROD_W-1:0] s;
        logic [PY_W-1:0]           y;
        logic [PY_W-SAMPLE_BITS:0] hi;
        s  = p + PAN_RND;
        y  = s[PPROD_W-1:15];
        hi = y[PY_W-1:SAMPLE_BITS-1];
        if ((hi == '0) || (hi == '1))
            return y[SAMPLE_BITS-1:0];
        else if (y[PY_W-1])
            return SAT_LO;
        else
            return SAT_HI;
    endfunction

    logic signed [SAMPLE_BITS-1:0] in_l_reg;
    logic signed [SAMPLE_BITS-1:0] in_r_reg;
    logic [GAIN_W-1:0]             gain_reg;
    logic [GAIN_W-1:0]             gain_next;
    logic signed [GPROD_W-1:0]     gprod_reg;
    logic signed [CH_W-1:0]        chl_reg;
    logic signed [CH_W-1:0]        chr_reg;
    logic signed [CH_W-1:0]        mid_reg;
    logic signed [SPROD_W-1:0]     sprod_reg;
    logic                          neg_reg;
    logic [AMAG_W-1:0]             amag_reg;
    logic [KMAG_W-1:0]             kmag_reg;
    logic signed [PPROD_W-1:0]     pl_reg;
    logic signed [PPROD_W-1:0]     pr_reg;
    logic [2*SAMPLE_BITS-1:0]      out_reg;
    logic                          out_valid_reg;

    logic signed [DELTA_W-1:0]     delta;
    logic signed [GPROD_W-1:0]     gprod_next;
    logic signed [GPROD_W-1:0]     gsum;
    logic signed [GSTEP_W-1:0]     gstep;
    logic signed [DELTA_W+1:0]     gain_wide;
    logic signed [SMUL_W-1:0]      smul_l;
    logic signed [SMUL_W-1:0]      smul_r;
    logic signed [CH_W-1:0]        smp_l;
    logic signed [CH_W-1:0]        smp_r;
    logic signed [SUM_W-1:0]       ms_sum;
    logic signed [SUM_W-1:0]       ms_diff;
    logic signed [SPROD_W-1:0]     sprod_next;
    logic signed [SPROD_W-1:0]     side_sum;
    logic signed [CH_W-1:0]        side;
    logic signed [CH_W-1:0]        clip_x;
    logic signed [CH_W-1:0]        clip_abs;
    logic [MAG_W-1:0]              mag;
    logic [A_W-1:0]                clip_a;
    logic signed [CH_W-1:0]        quo_ext;
    logic signed [CH_W-1:0]        clip_y;

    assign clip_en   = (cfg.drive_amount > DRIVE_ON);
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Gain smoothing: a step of about 0.002 of the distance, never less than one LSB.
    assign delta      = $signed({1'b0, cfg.target_gain}) - $signed({1'b0, gain_reg});
    assign gprod_next = GPROD_W'(delta) * GPROD_W'($signed({1'b0, SMOOTH_COEF}));
    assign gsum       = gprod_reg + GAIN_RND;

    always_comb
    begin
        gstep = $signed(gsum[GPROD_W-1:GAIN_FRAC]);
        if ((gstep == '0) && (delta != '0))
        begin
            gstep = delta[DELTA_W-1] ? -GSTEP_W'(1) : GSTEP_W'(1);
        end
        gain_wide = $signed({3'b000, gain_reg}) + (DELTA_W+2)'(gstep);
        gain_next = gain_wide[GAIN_W-1:0];
    end

    assign smul_l = SMUL_W'(in_l_reg) * SMUL_W'($signed({1'b0, gain_reg})) + SMP_RND;
    assign smul_r = SMUL_W'(in_r_reg) * SMUL_W'($signed({1'b0, gain_reg})) + SMP_RND;
    assign smp_l  = CH_W'($signed(smul_l[SMUL_W-1:GAIN_FRAC]));
    assign smp_r  = CH_W'($signed(smul_r[SMUL_W-1:GAIN_FRAC]));

    assign ms_sum     = SUM_W'(chl_reg) + SUM_W'(chr_reg) + SUM_W'(1);
    assign ms_diff    = SUM_W'(chl_reg) - SUM_W'(chr_reg);
    assign sprod_next = SPROD_W'(ms_diff) * SPROD_W'($signed({1'b0, cfg.stereo_width}));
    assign side_sum   = sprod_reg + SIDE_RND;
    assign side       = side_sum[CH_W+14:15];

    // Soft clip operands: the magnitude feeds both products, the sign comes back after.
    assign clip_x   = cmd.ch ? chr_reg : chl_reg;
    assign clip_abs = clip_x[CH_W-1] ? -clip_x : clip_x;
    assign mag      = clip_abs[MAG_W-1:0];
    assign clip_a   = A_W'(PI_Q10) + A_W'(cfg.drive_amount);

    assign div_den = (DEN_W'(PI_Q10) << CLIP_SH) + DEN_W'(kmag_reg[KMAG_W-1:10]);
    assign div_num = (NUM_W'(amag_reg) << CLIP_SH) + NUM_W'(div_den[DEN_W-1:1]);

    assign quo_ext = CH_W'(div_quo);
    assign clip_y  = neg_reg ? -quo_ext : quo_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_UNITY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gain_upd)
            begin
                gain_reg <= gain_next;
            end
            if (cmd.pan_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_l_reg <= $signed(in_data[SAMPLE_BITS-1:0]);
            in_r_reg <= $signed(in_data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        if (cmd.gain_mul)
        begin
            gprod_reg <= gprod_next;
        end
        if (cmd.smp_mul)
        begin
            chl_reg <= smp_l;
            chr_reg <= smp_r;
        end
        if (cmd.ms_mul)
        begin
            mid_reg   <= ms_sum[SUM_W-1:1];
            sprod_reg <= sprod_next;
        end
        if (cmd.ms_add)
        begin
            chl_reg <= mid_reg + side;
            chr_reg <= mid_reg - side;
        end
        if (cmd.clip_mul)
        begin
            neg_reg  <= clip_x[CH_W-1];
            amag_reg <= AMAG_W'(clip_a) * AMAG_W'(mag);
            kmag_reg <= KMAG_W'(cfg.drive_amount) * KMAG_W'(mag);
        end
        if (cmd.clip_store)
        begin
            if (cmd.ch)
            begin
                chr_reg <= clip_y;
            end
            else
            begin
                chl_reg <= clip_y;
            end
        end
        if (cmd.pan_mul)
        begin
            pl_reg <= PPROD_W'(chl_reg) * PPROD_W'($signed({1'b0, cfg.pan_left_gain}));
            pr_reg <= PPROD_W'(chr_reg) * PPROD_W'($signed({1'b0, cfg.pan_right_gain}));
        end
        if (cmd.pan_fin)
        begin
            out_reg <= {pan_sat(pr_reg), pan_sat(pl_reg)};
        end
    end

endmodule

>>> tb/stereo_gain_width_drive_pan_unit_tb.sv
// Self-checking testbench of the stereo gain, width, drive and pan unit with its scoreboard.
module stereo_gain_width_drive_pan_unit_tb;
    import sgwdp_pkg::*;

    localparam int NUM_REGS     = 5;
    localparam int DRAIN_CYCLES = 100;
    localparam int WORDS_WANTED = 1550;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 3000;

    localparam logic [COEF_W-1:0] WIDTH_MAX = 16'd32768;
    localparam logic [COEF_W-1:0] DRIVE_MAX = 16'd40960;
    localparam logic [COEF_W-1:0] PAN_MAX   = 16'd46341;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    class pair_scoreboard;
        logic [GAIN_W-1:0] target_gain;
        logic [COEF_W-1:0] width;
        logic [COEF_W-1:0] drive;
        logic [COEF_W-1:0] pan_l;
        logic [COEF_W-1:0] pan_r;
        longint            gain_now;
        logic [2*SAMPLE_BITS-1:0] expected_pairs[$];
        int                mismatches;

        function new();
            target_gain = GAIN_UNITY;
            width       = WIDTH_UNITY;
            drive       = '0;
            pan_l       = PAN_UNITY;
            pan_r       = PAN_UNITY;
            gain_now    = longint'(GAIN_UNITY);
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TARGET_GAIN:  target_gain = val[GAIN_W-1:0];
                REG_STEREO_WIDTH: width       = val[COEF_W-1:0];
                REG_DRIVE_AMOUNT: drive       = val[COEF_W-1:0];
                REG_PAN_LEFT:     pan_l       = val[COEF_W-1:0];
                REG_PAN_RIGHT:    pan_r       = val[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint round_shift(longint x, int n);
            return (x + (longint'(1) << (n - 1))) >>> n;
        endfunction

        // Rational soft clip on the magnitude, with the sign put back afterwards.
        function longint soft_clip(longint x);
            longint unsigned kk, pi, a, mag, b, d, q;
            kk  = longint'(drive);
            pi  = longint'(PI_Q10);
            a   = pi + kk;
            mag = (x < 0) ? -x : x;
            b   = mag << CLIP_SH;
            d   = (pi << CLIP_SH) + ((kk * mag) >> 10);
            q   = a * (b / d) + (a * (b % d) + d / 2) / d;
            if (x < 0)
                return -longint'(q);
            return longint'(q);
        endfunction

        function logic [SAMPLE_BITS-1:0] pan_sat(longint x, logic [COEF_W-1:0] g);
            longint gg, y, hi, lo;
            gg = longint'(g);
            hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            lo = -(longint'(1) << (SAMPLE_BITS - 1));
            y  = round_shift(x * gg, 15);
            if (y > hi)
                y = hi;
            if (y < lo)
                y = lo;
            return y[SAMPLE_BITS-1:0];
        endfunction

        function void note_input(logic signed [SAMPLE_BITS-1:0] l_in,
                                 logic signed [SAMPLE_BITS-1:0] r_in);
            longint tg, delta, stp, lin, rin, wd, l, r, mid, side;
            tg    = longint'(target_gain);
            delta = tg - gain_now;
            stp   = round_shift(delta * 2097, 20);
            // Near the target the step would round away, so it moves by one LSB.
            if (stp == 0 && delta != 0)
                stp = (delta > 0) ? 1 : -1;
            gain_now = gain_now + stp;

            lin  = longint'(l_in);
            rin  = longint'(r_in);
            wd   = longint'(width);
            l    = round_shift(lin * gain_now, 20);
            r    = round_shift(rin * gain_now, 20);
            mid  = round_shift(l + r, 1);
            side = round_shift((l - r) * wd, 15);
            l    = mid + side;
            r    = mid - side;
            if (drive > DRIVE_ON)
            begin
                l = soft_clip(l);
                r = soft_clip(r);
            end
            expected_pairs.push_back({pan_sat(r, pan_r), pan_sat(l, pan_l)});
        endfunction

        function void check_output(logic [2*SAMPLE_BITS-1:0] got);
            logic [2*SAMPLE_BITS-1:0] want;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: left %h right %h",
                             got[SAMPLE_BITS-1:0], got[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (want[SAMPLE_BITS-1:0] != got[SAMPLE_BITS-1:0] ||
                    want[2*SAMPLE_BITS-1:SAMPLE_BITS] != got[2*SAMPLE_BITS-1:SAMPLE_BITS])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output mismatch: left exp %h got %h, right exp %h got %h",
                                 want[SAMPLE_BITS-1:0], got[SAMPLE_BITS-1:0],
                                 want[2*SAMPLE_BITS-1:SAMPLE_BITS],
                                 got[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                end
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;   // left_in, right_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;         // left_out, right_out
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    pair_scoreboard sb;
    int words_in   = 0;
    int words_sent = 0;
    int burst_left = 1;

    stereo_gain_width_drive_pan_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Register writes and both handshakes are observed at the same edge the block sees them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_input(s_axis_tdata[SAMPLE_BITS-1:0],
                              s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata[2*SAMPLE_BITS-1:0]);
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int next_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4:          return $urandom_range(40, 90);
            default:    return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic send_item(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = next_gap();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops offering words and waits until every result is back and the block is quiet.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_extremes();
        send_item(SMP_MAX, SMP_MIN);
        send_item(SMP_MIN, SMP_MAX);
        send_item(SMP_MAX, SMP_MAX);
        send_item(SMP_MIN, SMP_MIN);
        send_item(24'sd12345, -24'sd999);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2:
            begin
                v = int'($urandom_range(0, 511)) - 256;
                return v[SAMPLE_BITS-1:0];
            end
            3:
            begin
                v = int'($urandom_range(0, 2)) - 1;
                return v[SAMPLE_BITS-1:0];
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_UNITY;
            1:       return '0;
            2:       return {GAIN_W{1'b1}};
            3:       return CFG_DATA_W'($urandom_range(0, 4 * GAIN_UNITY));
            4:       return CFG_DATA_W'(GAIN_UNITY / 2 + $urandom_range(0, GAIN_UNITY));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Full-width random data also drives the bits above a 16-bit register.
    function automatic logic [CFG_DATA_W-1:0] pick_coef(logic [COEF_W-1:0] rst_v,
                                                        logic [COEF_W-1:0] hi_v,
                                                        logic [COEF_W-1:0] knee_v);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(rst_v);
            2:       return CFG_DATA_W'(hi_v);
            3:       return CFG_DATA_W'(knee_v);
            4:       return CFG_DATA_W'(knee_v) + 1'b1;
            5:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, hi_v));
        endcase
    endfunction

    task automatic random_config();
        if ($urandom_range(0, 3) != 0)
            cfg_write(REG_TARGET_GAIN, pick_gain());
        if ($urandom_range(0, 3) != 0)
            cfg_write(REG_STEREO_WIDTH, pick_coef(WIDTH_UNITY, WIDTH_MAX, WIDTH_UNITY));
        if ($urandom_range(0, 3) != 0)
            cfg_write(REG_DRIVE_AMOUNT, pick_coef('0, DRIVE_MAX, DRIVE_ON));
        if ($urandom_range(0, 3) != 0)
            cfg_write(REG_PAN_LEFT, pick_coef(PAN_UNITY, PAN_MAX, PAN_UNITY));
        if ($urandom_range(0, 3) != 0)
            cfg_write(REG_PAN_RIGHT, pick_coef(PAN_UNITY, PAN_MAX, PAN_UNITY));
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
    endtask

    // The receiver follows a changing stall pattern, with one long hold-off that fills the block.
    initial
    begin : receiver
        int  seg_left;
        int  mode;
        int  hold_left;
        bit  hold_done;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_in >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (seg_left % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int n_items;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A target just above the gain: the smoothing moves by single LSBs and lands on it.
        cfg_write(REG_TARGET_GAIN, GAIN_UNITY + 24'd3);
        send_item('0, '0);
        send_item(24'sd1, -24'sd1);
        send_extremes();
        finish_phase();

        // Every register at the top of its width, and writes to unused indices.
        cfg_write(REG_TARGET_GAIN, {CFG_DATA_W{1'b1}});
        cfg_write(REG_STEREO_WIDTH, {CFG_DATA_W{1'b1}});
        cfg_write(REG_DRIVE_AMOUNT, {CFG_DATA_W{1'b1}});
        cfg_write(REG_PAN_LEFT, {CFG_DATA_W{1'b1}});
        cfg_write(REG_PAN_RIGHT, {CFG_DATA_W{1'b1}});
        for (int i = 0; i < 3; i++)
            cfg_write(CFG_IDX_W'(NUM_REGS + i), CFG_DATA_W'($urandom));
        send_extremes();
        finish_phase();

        // Mono, the soft clip just on, pan hard left, target gain zero.
        cfg_write(REG_TARGET_GAIN, '0);
        cfg_write(REG_STEREO_WIDTH, '0);
        cfg_write(REG_DRIVE_AMOUNT, CFG_DATA_W'(DRIVE_ON) + 1'b1);
        cfg_write(REG_PAN_LEFT, CFG_DATA_W'(PAN_MAX));
        cfg_write(REG_PAN_RIGHT, '0);
        send_extremes();
        finish_phase();

        // Width at twice unity, the soft clip just off, pan hard right.
        cfg_write(REG_TARGET_GAIN, {GAIN_W{1'b1}});
        cfg_write(REG_STEREO_WIDTH, CFG_DATA_W'(WIDTH_MAX));
        cfg_write(REG_DRIVE_AMOUNT, CFG_DATA_W'(DRIVE_ON));
        cfg_write(REG_PAN_LEFT, '0);
        cfg_write(REG_PAN_RIGHT, CFG_DATA_W'(PAN_MAX));
        send_extremes();
        finish_phase();

        // A long run toward zero gain lets the smoothed gain fall a long way.
        random_config();
        cfg_write(REG_TARGET_GAIN, '0);
        repeat (250) send_item(pick_sample(), pick_sample());
        finish_phase();

        while (words_sent < WORDS_WANTED)
        begin
            random_config();
            n_items = $urandom_range(10, 120);
            repeat (n_items) send_item(pick_sample(), pick_sample());
            finish_phase();
        end

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
